/* hdl/dsd_pkg.sv */
// Shared constants and the digit-to-segment decode for the decimal digit sequencer.
package dsd_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CODE_W         = 8;
  localparam int unsigned POS_W          = 3;
  localparam int unsigned NUM_DIGITS_DEF = 8;
  localparam int unsigned RUN_CAP        = 8;
  localparam int unsigned MIN_RUN        = 2;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam logic [POS_W-1:0]  POINT_RESET = 3'd6;
  localparam logic [POS_W-1:0]  FIRST_POS   = 3'd7;
  localparam logic [CODE_W-1:0] POINT_BIT   = 8'h01;

  // Reciprocal of ten for a 32-bit dividend: q = (x * DIV10_MAGIC) >> DIV10_SHIFT.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [POS_W-1:0]   pos_t;

  // Common-cathode segment patterns, a..g in bits 7..1.
  function automatic code_t seg_code(input logic [3:0] digit);
    code_t code;
    case (digit)
      4'd0:    code = 8'hfc;
      4'd1:    code = 8'h60;
      4'd2:    code = 8'hda;
      4'd3:    code = 8'hf2;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'hb6;
      4'd6:    code = 8'hbe;
      4'd7:    code = 8'he0;
      4'd8:    code = 8'hfe;
      4'd9:    code = 8'hf6;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* hdl/dsd_if.sv */
// Valid/ready channel interfaces for values, digit results and the point register.
interface dsd_value_if;
  logic               valid;
  logic               ready;
  dsd_pkg::value_t    value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface dsd_result_if;
  logic               valid;
  logic               ready;
  dsd_pkg::code_t     segment_code;
  dsd_pkg::pos_t      digit_position;
  logic               last_digit;
  modport source (output valid, output segment_code, output digit_position,
                  output last_digit, input ready);
  modport sink   (input valid, input segment_code, input digit_position,
                  input last_digit, output ready);
endinterface

interface dsd_cfg_if;
  logic               valid;
  logic               ready;
  dsd_pkg::pos_t      point_digit;
  modport source (output valid, output point_digit, input ready);
  modport sink   (input valid, input point_digit, output ready);
endinterface

/* hdl/dsd_front.sv */
// Front end: accepts values and holds them in a short queue ahead of the digit engine.
module dsd_front (
  input logic         clk,
  input logic         rst_n,
  dsd_value_if.sink   in,
  dsd_value_if.source q
);
  import dsd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  value_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push;
  logic               pop;

  assign in.ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign q.valid  = (count_r != '0);
  assign q.value  = mem_r[rd_ptr_r];
  assign push     = in.valid && in.ready;
  assign pop      = q.valid && q.ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in.value;
    end
  end

endmodule

/* hdl/dsd_back.sv */
// Back end: peels one decimal digit per cycle unless stalled by the output, and registers the segment result.
module dsd_back #(
  parameter int unsigned NUM_DIGITS = dsd_pkg::NUM_DIGITS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  dsd_value_if.sink     q,
  dsd_result_if.source  out,
  input dsd_pkg::pos_t  point_digit
);
  import dsd_pkg::*;

  localparam int unsigned RUN_LIM = (NUM_DIGITS > RUN_CAP) ? RUN_CAP :
                                    ((NUM_DIGITS < MIN_RUN) ? MIN_RUN : NUM_DIGITS);
  localparam logic [POS_W-1:0] LAST_K = POS_W'(RUN_LIM - 1);

  logic               busy_r;
  value_t             rest_r;
  logic [POS_W-1:0]   k_r;
  logic               out_valid_r;
  code_t              code_r;
  pos_t               pos_r;
  logic               last_r;

  logic [63:0]        prod;
  value_t             quo;
  value_t             quo_x10;
  logic [3:0]         digit;
  pos_t               pos;
  code_t              code;
  logic               last;
  logic               advance;
  logic               take;

  always_comb begin
    prod    = {32'b0, rest_r} * {32'b0, DIV10_MAGIC};
    quo     = VALUE_W'(prod >> DIV10_SHIFT);
    quo_x10 = (quo << 3) + (quo << 1);
    digit   = 4'(rest_r - quo_x10);
    pos     = FIRST_POS - k_r;
    code    = seg_code(digit);
    if (pos == point_digit) begin
      code = code | POINT_BIT;
    end
    // A run always has at least two digits and never more than the limit.
    last    = ((quo == '0) && (k_r != '0)) || (k_r == LAST_K);
    advance = busy_r && (!out_valid_r || out.ready);
    take    = !busy_r || (advance && last);
  end

  assign q.ready            = take;
  assign out.valid          = out_valid_r;
  assign out.segment_code   = code_r;
  assign out.digit_position = pos_r;
  assign out.last_digit     = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (take && q.valid) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (advance) begin
        busy_r <= !last;
        k_r    <= k_r + 1'b1;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && q.valid) begin
      rest_r <= q.value;
    end else if (advance) begin
      rest_r <= quo;
    end
    if (advance) begin
      code_r <= code;
      pos_r  <= pos;
      last_r <= last;
    end
  end

endmodule

/* hdl/decimal_seven_segment_digit_sequencer.sv */
// Top level of the decimal seven-segment digit sequencer.
// Each accepted 32-bit value produces one word per decimal digit, least significant first,
// at digit positions 7 downward, with the decimal point added at the position held in the
// point register (reset 6, written through the cfg channel; the user must write it only
// while idle, as the block itself does not enforce this). A value yields between two and
// max(2, min(NUM_DIGITS, 8)) words, stopping after its highest nonzero digit, but never
// before the second word or past that limit. The back end produces one digit word per clock
// through a multiply-by-reciprocal divide by ten; a two-entry queue in front lets new values
// arrive while a run is in progress. The engine holds whenever a word waits untaken in the
// output register.
module decimal_seven_segment_digit_sequencer #(
  parameter int unsigned NUM_DIGITS = dsd_pkg::NUM_DIGITS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  dsd_value_if.sink     in,
  dsd_result_if.source  out,
  dsd_cfg_if.sink       cfg
);
  import dsd_pkg::*;

  pos_t point_digit_r;

  dsd_value_if q_ch ();

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_digit_r <= POINT_RESET;
    end else if (cfg.valid) begin
      point_digit_r <= cfg.point_digit;
    end
  end

  dsd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in    (in),
    .q     (q_ch.source)
  );

  dsd_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q           (q_ch.sink),
    .out         (out),
    .point_digit (point_digit_r)
  );

endmodule
